### sv/mep_pkg.sv
// Shared types and constants for the midpoint ellipse plotter.
// No dependencies; imported by the interfaces and every module of the block.
package mep_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int RADIUS_BITS_DEF = 12;
    localparam int ERROR_BITS_DEF  = 48;

    localparam int PIXEL_BITS   = 12;
    localparam int COLOR_BITS   = 32;
    localparam int FRAME_BITS   = 13;
    localparam int CFG_IDX_BITS = 1;
    localparam int NPOINTS      = 4;

    localparam logic [FRAME_BITS-1:0] FRAME_MAX     = 13'd4096;
    localparam logic [FRAME_BITS-1:0] FRAME_W_RESET = 13'd640;
    localparam logic [FRAME_BITS-1:0] FRAME_H_RESET = 13'd480;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ARC,
        PH_TAIL
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_UPDX,
        S_UPDY,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic mul1;
        logic mul2;
        logic mul3;
        logic arc_step;
        logic tail_step;
        logic upd_x;
        logic upd_y;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_phase phase;
        logic   mask_empty;
    } t_status;

endpackage

### sv/mep_in_if.sv
// Request channel of the ellipse plotter: valid, ready and the start/step payload.
// Depends on mep_pkg for default widths and the color width.
interface mep_in_if import mep_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic        [RADIUS_BITS-1:0] radius_a;
    logic        [RADIUS_BITS-1:0] radius_b;
    logic        [COLOR_BITS-1:0]  color;

    modport source (
        output valid, op, center_x, center_y, radius_a, radius_b, color,
        input  ready
    );

    modport sink (
        input  valid, op, center_x, center_y, radius_a, radius_b, color,
        output ready
    );
endinterface

### sv/mep_out_if.sv
// Point channel of the ellipse plotter: valid, ready and one in-frame point.
// Depends on mep_pkg for the pixel and color widths.
interface mep_out_if import mep_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last;
    logic                  done_res;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last, done_res,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last, done_res,
        output ready
    );
endinterface

### sv/midpoint_ellipse_plotter_top.sv
// Midpoint ellipse plotter, top level: a start request loads center, radii and
// color in the accept, then S_MUL1 and S_MUL2 multiply and S_MUL3 adds, with no
// points; an arc step runs the accept, the error update in S_UPDX and S_UPDY and
// S_EMIT for its n (0..4) in-frame points, a tail step the accept and S_EMIT for
// its n (0..2). The point sequencer loads one point per cycle into the output
// register unless the output stalls; a stalled output adds its wait. Depends on
// mep_pkg, mep_in_if, mep_out_if, mep_ctrl and mep_datapath.
module midpoint_ellipse_plotter_top import mep_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int ERROR_BITS  = ERROR_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    mep_in_if.sink                  i_in,
    mep_out_if.source               o_out,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [FRAME_BITS-1:0]   i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    mep_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    mep_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .ERROR_BITS  (ERROR_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_center_x    (i_in.center_x),
        .i_center_y    (i_in.center_y),
        .i_radius_a    (i_in.radius_a),
        .i_radius_b    (i_in.radius_b),
        .i_color       (i_in.color),
        .i_ready       (o_out.ready),
        .o_valid       (o_out.valid),
        .o_pixel_x     (o_out.pixel_x),
        .o_pixel_y     (o_out.pixel_y),
        .o_pixel_color (o_out.pixel_color),
        .o_last        (o_out.last),
        .o_done_res    (o_out.done_res)
    );

endmodule

### sv/mep_ctrl.sv
// Sequencer of the ellipse plotter: takes requests and issues datapath commands.
// Depends on mep_pkg for the state, phase, command and status types.
module mep_ctrl import mep_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_op,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_START) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_MUL1;
                    end else begin
                        unique case (i_status.phase)
                            PH_ARC: begin
                                o_cmd.arc_step = 1'b1;
                                n_state        = S_UPDX;
                            end
                            PH_TAIL: begin
                                o_cmd.tail_step = 1'b1;
                                n_state         = S_EMIT;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = S_IDLE;
            end
            S_UPDX: begin
                o_cmd.upd_x = 1'b1;
                n_state     = S_UPDY;
            end
            S_UPDY: begin
                o_cmd.upd_y = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.mask_empty) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/mep_datapath.sv
// Datapath of the ellipse plotter: ellipse state, error terms, point capture,
// clipping, frame registers and the output register. Depends on mep_pkg.
module mep_datapath import mep_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int ERROR_BITS  = ERROR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [FRAME_BITS-1:0]         i_cfg_data,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    input  logic        [RADIUS_BITS-1:0] i_radius_a,
    input  logic        [RADIUS_BITS-1:0] i_radius_b,
    input  logic        [COLOR_BITS-1:0]  i_color,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [PIXEL_BITS-1:0]         o_pixel_x,
    output logic [PIXEL_BITS-1:0]         o_pixel_y,
    output logic [COLOR_BITS-1:0]         o_pixel_color,
    output logic                          o_last,
    output logic                          o_done_res
);

    localparam int OW   = RADIUS_BITS + 2;
    localparam int XW0  = (COORD_BITS > OW) ? COORD_BITS : OW;
    localparam int XW   = ((XW0 > FRAME_BITS) ? XW0 : FRAME_BITS) + 1;
    localparam int PW   = OW + 2 * RADIUS_BITS + 1;
    localparam int SELW = $clog2(NPOINTS);
    localparam logic [NPOINTS-1:0] TAIL_MASK = 4'b0101;

    logic signed [COORD_BITS-1:0]    r_cx;
    logic signed [COORD_BITS-1:0]    r_cy;
    logic        [RADIUS_BITS-1:0]   r_a;
    logic        [RADIUS_BITS-1:0]   r_b;
    logic        [COLOR_BITS-1:0]    r_color;
    logic signed [OW-1:0]            r_ox;
    logic signed [OW-1:0]            r_oy;
    logic        [2*RADIUS_BITS-1:0] r_a2;
    logic        [2*RADIUS_BITS-1:0] r_b2;
    logic signed [ERROR_BITS-1:0]    r_sx;
    logic signed [ERROR_BITS-1:0]    r_sy;
    logic signed [ERROR_BITS-1:0]    r_err;
    logic signed [ERROR_BITS-1:0]    r_dx;
    logic signed [ERROR_BITS-1:0]    r_dy;
    logic                            r_c1;
    logic                            r_c2;
    logic                            r_fin;
    t_phase                          r_phase;
    logic        [NPOINTS-1:0]       r_mask;
    logic        [PIXEL_BITS-1:0]    r_px [NPOINTS];
    logic        [PIXEL_BITS-1:0]    r_py [NPOINTS];
    logic        [FRAME_BITS-1:0]    r_fw;
    logic        [FRAME_BITS-1:0]    r_fh;
    logic                            r_ov;
    logic        [PIXEL_BITS-1:0]    r_opx;
    logic        [PIXEL_BITS-1:0]    r_opy;
    logic        [COLOR_BITS-1:0]    r_ocolor;
    logic                            r_olast;
    logic                            r_odone;

    logic signed [OW-1:0]            n_oy_inc;
    logic signed [OW-1:0]            n_oy_fin;
    logic signed [OW-1:0]            w_b_s;
    logic signed [OW-1:0]            w_xo;
    logic signed [OW-1:0]            w_yo;
    logic signed [OW-1:0]            w_k;
    logic signed [PW-1:0]            w_prod;
    logic signed [ERROR_BITS-1:0]    w_e2;
    logic signed [ERROR_BITS-1:0]    n_sx;
    logic signed [ERROR_BITS-1:0]    n_sy;
    logic        [FRAME_BITS-1:0]    w_lw;
    logic        [FRAME_BITS-1:0]    w_lh;
    logic signed [XW-1:0]            w_cx;
    logic signed [XW-1:0]            w_cy;
    logic signed [XW-1:0]            w_xoe;
    logic signed [XW-1:0]            w_yoe;
    logic signed [XW-1:0]            w_x [NPOINTS];
    logic signed [XW-1:0]            w_y [NPOINTS];
    logic        [NPOINTS-1:0]       w_in;
    logic        [NPOINTS-1:0]       n_mask_cap;
    logic        [SELW-1:0]          w_sel;
    logic        [NPOINTS-1:0]       n_mask_rest;
    logic                            w_load;
    logic                            w_capture;

    assign n_oy_inc = r_oy + OW'(1);
    assign n_oy_fin = r_c2 ? n_oy_inc : r_oy;
    assign w_b_s    = $signed({2'b00, r_b});
    assign w_xo     = i_cmd.tail_step ? '0 : r_ox;
    assign w_yo     = i_cmd.tail_step ? n_oy_inc : r_oy;

    assign w_k    = $signed({{(OW-1){1'b0}}, 1'b1}) - $signed({1'b0, r_a, 1'b0});
    assign w_prod = PW'(w_k) * PW'($signed({1'b0, r_b2}));

    assign w_e2 = r_err <<< 1;
    assign n_sx = r_sx + r_dx;
    assign n_sy = r_sy + r_dy;

    assign w_lw = (r_fw > FRAME_MAX) ? FRAME_MAX : r_fw;
    assign w_lh = (r_fh > FRAME_MAX) ? FRAME_MAX : r_fh;

    assign w_cx  = XW'(r_cx);
    assign w_cy  = XW'(r_cy);
    assign w_xoe = XW'(w_xo);
    assign w_yoe = XW'(w_yo);

    assign w_x[0] = w_cx - w_xoe;
    assign w_y[0] = w_cy + w_yoe;
    assign w_x[1] = w_cx + w_xoe;
    assign w_y[1] = w_cy + w_yoe;
    assign w_x[2] = w_cx + w_xoe;
    assign w_y[2] = w_cy - w_yoe;
    assign w_x[3] = w_cx - w_xoe;
    assign w_y[3] = w_cy - w_yoe;

    always_comb begin
        for (int i = 0; i < NPOINTS; i++) begin
            w_in[i] = !w_x[i][XW-1] && !w_y[i][XW-1]
                   && ($unsigned(w_x[i]) < XW'(w_lw))
                   && ($unsigned(w_y[i]) < XW'(w_lh));
        end
    end

    assign n_mask_cap = i_cmd.tail_step ? (w_in & TAIL_MASK) : w_in;
    assign w_capture  = i_cmd.arc_step || i_cmd.tail_step;

    always_comb begin
        w_sel = '0;
        for (int i = NPOINTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_sel = SELW'(i);
            end
        end
    end

    assign n_mask_rest = r_mask & ~(NPOINTS'(1) << w_sel);
    assign w_load      = i_cmd.emit && (r_mask != '0) && (!r_ov || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= FRAME_W_RESET;
            r_fh <= FRAME_H_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ellipse state, error terms and captured points
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_a     <= i_radius_a;
            r_b     <= i_radius_b;
            r_color <= i_color;
            r_ox    <= OW'(-$signed({2'b00, i_radius_a}));
            r_oy    <= '0;
        end
        if (i_cmd.mul1) begin
            r_a2 <= (2*RADIUS_BITS)'(r_a) * (2*RADIUS_BITS)'(r_a);
            r_b2 <= (2*RADIUS_BITS)'(r_b) * (2*RADIUS_BITS)'(r_b);
        end
        if (i_cmd.mul2) begin
            r_sx <= ERROR_BITS'(w_prod);
            r_sy <= ERROR_BITS'(r_a2);
            r_dx <= ERROR_BITS'({r_b2, 1'b0});
            r_dy <= ERROR_BITS'({r_a2, 1'b0});
        end
        if (i_cmd.mul3) begin
            r_err <= r_sx + r_sy;
        end
        if (i_cmd.arc_step) begin
            r_c1  <= (w_e2 >= r_sx);
            r_c2  <= (r_sy >= w_e2);
            r_fin <= 1'b0;
        end
        if (i_cmd.upd_x && r_c1) begin
            r_ox  <= r_ox + OW'(1);
            r_sx  <= n_sx;
            r_err <= r_err + n_sx;
        end
        if (i_cmd.upd_y) begin
            if (r_c2) begin
                r_oy  <= n_oy_inc;
                r_sy  <= n_sy;
                r_err <= r_err + n_sy;
            end
            if (!r_ox[OW-1] && (r_ox != '0) && (n_oy_fin >= w_b_s)) begin
                r_fin <= 1'b1;
            end
        end
        if (i_cmd.tail_step) begin
            r_oy  <= n_oy_inc;
            r_fin <= (n_oy_inc >= w_b_s);
        end
        if (w_capture) begin
            for (int i = 0; i < NPOINTS; i++) begin
                r_px[i] <= w_x[i][PIXEL_BITS-1:0];
                r_py[i] <= w_y[i][PIXEL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_cmd.start) begin
            r_phase <= PH_ARC;
        end else if (i_cmd.upd_y && !r_ox[OW-1] && (r_ox != '0)) begin
            r_phase <= (n_oy_fin < w_b_s) ? PH_TAIL : PH_IDLE;
        end else if (i_cmd.tail_step && (n_oy_inc >= w_b_s)) begin
            r_phase <= PH_IDLE;
        end
    end

    // pending points and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (w_capture) begin
                r_mask <= n_mask_cap;
            end else if (w_load) begin
                r_mask <= n_mask_rest;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_opx    <= r_px[w_sel];
            r_opy    <= r_py[w_sel];
            r_ocolor <= r_color;
            r_olast  <= (n_mask_rest == '0);
            r_odone  <= (n_mask_rest == '0) && r_fin;
        end
    end

    assign o_status.phase      = r_phase;
    assign o_status.mask_empty = (r_mask == '0);

    assign o_valid       = r_ov;
    assign o_pixel_x     = r_opx;
    assign o_pixel_y     = r_opy;
    assign o_pixel_color = r_ocolor;
    assign o_last        = r_olast;
    assign o_done_res    = r_odone;

    a_start_arc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> r_phase == PH_ARC)
        else $error("phase not arc after start");

    a_tail_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tail_step |=> !r_mask[1] && !r_mask[3])
        else $error("tail step captured an off-axis point");

    a_load_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(i_cmd.emit))
        else $error("point loaded outside emit");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_odone) |-> r_olast)
        else $error("done without last");

endmodule

### dv/mep_point_checker.sv
`timescale 1ns / 100ps
// Point scoreboard for the midpoint ellipse plotter: follows frame size writes,
// predicts the points of each accepted request and checks every point that leaves.
// Depends on mep_pkg, mep_in_if and mep_out_if.
module mep_point_checker import mep_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    mep_in_if                       i_req,
    mep_out_if                      i_pt,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [FRAME_BITS-1:0]   i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_requests,
    output int                      o_points,
    output int                      o_ellipses
);
    localparam int OFS_BITS = RADIUS_BITS_DEF + 2;
    localparam int ERR_BITS = ERROR_BITS_DEF;

    typedef struct {
        logic [PIXEL_BITS-1:0] x;
        logic [PIXEL_BITS-1:0] y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
        logic                  done;
    } t_point;

    t_point expected_points[$];
    t_point step_points[$];

    t_phase                      draw_phase;
    logic signed [OFS_BITS-1:0]  ofs_x;
    logic signed [OFS_BITS-1:0]  ofs_y;
    logic signed [ERR_BITS-1:0]  dx_term;
    logic signed [ERR_BITS-1:0]  dy_term;
    logic signed [ERR_BITS-1:0]  err_term;
    int                          cen_x;
    int                          cen_y;
    logic [RADIUS_BITS_DEF-1:0]  rad_a;
    logic [RADIUS_BITS_DEF-1:0]  rad_b;
    logic [COLOR_BITS-1:0]       ink;
    logic [FRAME_BITS-1:0]       frame_w;
    logic [FRAME_BITS-1:0]       frame_h;
    int                          mismatches;
    int                          requests;
    int                          points;
    int                          ellipses;

    function automatic void plot_point(int px, int py);
        int     lw;
        int     lh;
        t_point p;
        lw = (frame_w > FRAME_MAX) ? int'(FRAME_MAX) : int'(frame_w);
        lh = (frame_h > FRAME_MAX) ? int'(FRAME_MAX) : int'(frame_h);
        if (px < 0 || py < 0 || px >= lw || py >= lh) return;
        p.x = px[PIXEL_BITS-1:0];
        p.y = py[PIXEL_BITS-1:0];
        p.color = ink;
        p.last = 1'b0;
        p.done = 1'b0;
        step_points.push_back(p);
    endfunction

    function automatic void trace_ellipse(input logic op,
                                          input logic signed [COORD_BITS_DEF-1:0] cx, cy,
                                          input logic [RADIUS_BITS_DEF-1:0] a, b,
                                          input logic [COLOR_BITS-1:0] color);
        logic signed [ERR_BITS-1:0] e2;
        longint                     la;
        longint                     lb;
        logic                       fin;
        fin = 1'b0;
        step_points.delete();
        if (op == OP_START) begin
            cen_x = int'(cx);
            cen_y = int'(cy);
            rad_a = a;
            rad_b = b;
            ink = color;
            la = longint'(rad_a);
            lb = longint'(rad_b);
            ofs_x = OFS_BITS'(-la);
            ofs_y = '0;
            dx_term = ERR_BITS'((1 - 2 * la) * lb * lb);
            dy_term = ERR_BITS'(la * la);
            err_term = dx_term + dy_term;
            draw_phase = PH_ARC;
            return;
        end
        la = longint'(rad_a);
        lb = longint'(rad_b);
        case (draw_phase)
            PH_ARC: begin
                plot_point(cen_x - ofs_x, cen_y + ofs_y);
                plot_point(cen_x + ofs_x, cen_y + ofs_y);
                plot_point(cen_x + ofs_x, cen_y - ofs_y);
                plot_point(cen_x - ofs_x, cen_y - ofs_y);
                e2 = err_term <<< 1;
                if (e2 >= dx_term) begin
                    ofs_x = OFS_BITS'(ofs_x + 1);
                    dx_term = dx_term + ERR_BITS'(2 * lb * lb);
                    err_term = err_term + dx_term;
                end
                if (dy_term >= e2) begin
                    ofs_y = OFS_BITS'(ofs_y + 1);
                    dy_term = dy_term + ERR_BITS'(2 * la * la);
                    err_term = err_term + dy_term;
                end
                if (ofs_x > 0) begin
                    if (int'(ofs_y) < int'(rad_b)) draw_phase = PH_TAIL;
                    else fin = 1'b1;
                end
            end
            PH_TAIL: begin
                ofs_y = OFS_BITS'(ofs_y + 1);
                plot_point(cen_x, cen_y + ofs_y);
                plot_point(cen_x, cen_y - ofs_y);
                if (int'(ofs_y) >= int'(rad_b)) fin = 1'b1;
            end
            default: return;
        endcase
        if (fin) draw_phase = PH_IDLE;
        if (step_points.size() > 0) begin
            step_points[$].last = 1'b1;
            step_points[$].done = fin;
        end
        foreach (step_points[i]) expected_points.push_back(step_points[i]);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void match_point();
        t_point want;
        if (expected_points.size() == 0) begin
            $display("%0t: unexpected point, got x=%0d y=%0d color=%08h last=%0b done=%0b",
                     $time, i_pt.pixel_x, i_pt.pixel_y, i_pt.pixel_color, i_pt.last,
                     i_pt.done_res);
            mismatches++;
            return;
        end
        want = expected_points.pop_front();
        check_field("pixel_x", 32'(want.x), 32'(i_pt.pixel_x));
        check_field("pixel_y", 32'(want.y), 32'(i_pt.pixel_y));
        check_field("pixel_color", want.color, i_pt.pixel_color);
        check_field("last", 32'(want.last), 32'(i_pt.last));
        check_field("done_res", 32'(want.done), 32'(i_pt.done_res));
        points++;
        if (i_pt.done_res) ellipses++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_points.delete();
            draw_phase = PH_IDLE;
            ofs_x = '0;
            ofs_y = '0;
            dx_term = '0;
            dy_term = '0;
            err_term = '0;
            cen_x = 0;
            cen_y = 0;
            rad_a = '0;
            rad_b = '0;
            ink = '0;
            frame_w = FRAME_W_RESET;
            frame_h = FRAME_H_RESET;
            mismatches = 0;
            requests = 0;
            points = 0;
            ellipses = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  frame_w = i_cfg_data;
                    CFG_FRAME_HEIGHT: frame_h = i_cfg_data;
                endcase
            end
            if (i_pt.valid && i_pt.ready) match_point();
            if (i_req.valid && i_req.ready) begin
                requests++;
                trace_ellipse(i_req.op, i_req.center_x, i_req.center_y, i_req.radius_a,
                              i_req.radius_b, i_req.color);
            end
        end
        o_fail_count <= mismatches;
        o_pending <= expected_points.size();
        o_requests <= requests;
        o_points <= points;
        o_ellipses <= ellipses;
    end
endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the midpoint ellipse plotter: clock, reset, frame size writes,
// start/step requests and output back-pressure. Depends on mep_pkg, mep_in_if,
// mep_out_if, midpoint_ellipse_plotter_top and mep_point_checker.
module tb_top;
    import mep_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 250;
    localparam int SHAPE_BUDGET  = 20;
    localparam int NUM_FRAMES    = 6;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [FRAME_BITS-1:0]   cfg_data;
    int                      fail_count;
    int                      pending;
    int                      requests;
    int                      points;
    int                      ellipses;
    bit                      quiet;
    bit                      long_hold_req;
    logic [FRAME_BITS-1:0]   cur_w;
    logic [FRAME_BITS-1:0]   cur_h;

    mep_in_if  in_ch ();
    mep_out_if out_ch ();

    midpoint_ellipse_plotter_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mep_point_checker point_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (in_ch),
        .i_pt         (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_requests   (requests),
        .o_points     (points),
        .o_ellipses   (ellipses)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin : point_sink
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end else if (hold_left == 0 && !quiet) begin
                hold_left = gap_len();
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("%0t: no request or point moved for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic send_req(input logic op, input logic signed [15:0] cx, cy,
                            input logic [11:0] a, b, input logic [31:0] color);
        int gap;
        gap = quiet ? 0 : gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.center_x <= cx;
        in_ch.center_y <= cy;
        in_ch.radius_a <= a;
        in_ch.radius_b <= b;
        in_ch.color <= color;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic advance(input int n);
        repeat (n) send_req(OP_STEP, 16'($urandom), 16'($urandom), 12'($urandom),
                            12'($urandom), $urandom);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input logic [FRAME_BITS-1:0] w, h);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_idx <= CFG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    task automatic run_shapes(input int budget, input bit mid_pause);
        int                 sent;
        int                 lw;
        int                 lh;
        int                 n;
        int                 r;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [11:0]        a;
        logic [11:0]        b;
        sent = 0;
        lw = (cur_w > FRAME_MAX) ? int'(FRAME_MAX) : int'(cur_w);
        lh = (cur_h > FRAME_MAX) ? int'(FRAME_MAX) : int'(cur_h);
        while (sent < budget) begin
            if (mid_pause && sent > budget / 2) begin
                wait_drained();
                mid_pause = 1'b0;
            end
            r = $urandom_range(0, 9);
            if (r == 0) begin
                cx = 16'($urandom);
                cy = 16'($urandom);
            end else begin
                cx = 16'($urandom_range(0, lw + 8) - 4);
                cy = 16'($urandom_range(0, lh + 8) - 4);
            end
            r = $urandom_range(0, 19);
            if (r == 0) begin
                a = 12'($urandom);
                b = 12'($urandom);
                n = $urandom_range(1, 3);
            end else if (r < 3) begin
                a = 12'($urandom_range(6, 10));
                b = 12'($urandom_range(6, 10));
                n = a + b + 1;
            end else begin
                a = 12'($urandom_range(0, 6));
                b = 12'($urandom_range(0, 6));
                n = a + b + 1;
            end
            if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
            else if ($urandom_range(0, 9) == 0) n++;
            send_req(OP_START, cx, cy, a, b, $urandom);
            advance(n);
            sent += n + 1;
        end
    endtask

    initial begin
        logic [FRAME_BITS-1:0] widths [NUM_FRAMES];
        logic [FRAME_BITS-1:0] heights [NUM_FRAMES];
        widths = '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd0, 13'd640};
        heights = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd0, 13'd480};
        widths[4] = 13'($urandom_range(1, 4096));
        heights[4] = 13'($urandom_range(1, 4096));
        quiet = 1'b0;
        long_hold_req = 1'b0;
        cur_w = FRAME_W_RESET;
        cur_h = FRAME_H_RESET;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_FRAME_WIDTH;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.op <= OP_START;
        in_ch.center_x <= '0;
        in_ch.center_y <= '0;
        in_ch.radius_a <= '0;
        in_ch.radius_b <= '0;
        in_ch.color <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step while idle, then small shapes, extremes, abandoned shapes and a flat shape
        send_req(OP_STEP, 16'sd0, 16'sd0, 12'd0, 12'd0, 32'h0);
        send_req(OP_START, 16'sd100, 16'sd100, 12'd3, 12'd2, 32'hFFFF_FFFF);
        advance(6);
        send_req(OP_START, 16'sd0, 16'sd0, 12'd0, 12'd0, 32'h0);
        advance(2);
        send_req(OP_START, 16'sh7FFF, 16'sh8000, 12'd4095, 12'd4095, 32'hA5A5_5A5A);
        advance(2);
        send_req(OP_START, 16'sd639, 16'sd479, 12'd1, 12'd1, 32'h1234_5678);
        advance(3);
        send_req(OP_START, 16'sd5, 16'sd5, 12'd4, 12'd0, $urandom);
        advance(5);

        for (int ph = 0; ph < NUM_FRAMES; ph++) begin
            wait_drained();
            set_frame(widths[ph], heights[ph]);
            quiet = (ph == 1);
            if (ph == 0) long_hold_req = 1'b1;
            run_shapes(SHAPE_BUDGET, ph == 4);
        end
        quiet = 1'b0;
        wait_drained();

        $display("Sent %0d requests; %0d points checked, %0d ellipses reported done.",
                 requests, points, ellipses);
        $display("Frame sizes: reset value, 0, 1, 4096, 8191 and one random size per axis.");
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
